// File: hdl/lrc_pkg.sv
`default_nettype none

package lrc_pkg;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNC     = 3'd1;
    localparam logic [2:0] ST_CRC       = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_PAYLOAD   = 3'd4;
    localparam logic [2:0] ST_ROW_ID    = 3'd5;
    localparam logic [2:0] ST_FRAMING   = 3'd6;
    localparam logic [2:0] ST_UNKNOWN   = 3'd7;

    // chunk framing phases
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_IDS_LEN   = 3'd1;
    localparam logic [2:0] PH_IDS       = 3'd2;
    localparam logic [2:0] PH_COUNT     = 3'd3;
    localparam logic [2:0] PH_LEN       = 3'd4;
    localparam logic [2:0] PH_DATA      = 3'd5;
    localparam logic [2:0] PH_DONE      = 3'd6;
    localparam logic [2:0] PH_FAIL      = 3'd7;

    // record classes
    localparam logic [2:0] CL_COMMIT    = 3'd0;
    localparam logic [2:0] CL_BATCH     = 3'd1;
    localparam logic [2:0] CL_DELETE    = 3'd2;
    localparam logic [2:0] CL_UPDATE    = 3'd3;
    localparam logic [2:0] CL_UNKNOWN   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_COMMIT   = 3'd0;
    localparam logic [2:0] REG_INSERT   = 3'd1;
    localparam logic [2:0] REG_ADD_COL  = 3'd2;
    localparam logic [2:0] REG_DELETE   = 3'd3;
    localparam logic [2:0] REG_UPDATE   = 3'd4;

    localparam logic [31:0] CRC_POLY    = 32'h82F63B78;
    localparam logic [32:0] COMMIT_MIN  = 33'd29;
    localparam logic [32:0] DATA_HDR    = 33'd45;
    localparam logic [32:0] RECORD_MIN  = 33'd37;

    typedef struct packed {
        logic       clear;
        logic       start;
        logic [2:0] start_phase;
        logic       take;
    } frm_ctrl_t;

    // reflected crc-32c, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hdl/log_record_checker.sv
// log record checker
// in channel: one log byte per transfer (data_byte, buffer_end) on in_valid/in_ready.
// out channel: one result per record on out_valid/out_ready, given on the last crc
//   byte of a record, or on a byte with buffer_end set that ends the buffer inside
//   a record (status truncated).
// cfg port: cfg_write, cfg_index, cfg_data set the five type codes; write only
//   while the block is idle.
// a result is registered: the completing byte passes the input register, then
//   the result register. throughput: one byte per cycle unless a stalled
//   receiver holds a result; each byte passes once through the crc step, field
//   capture and framing logic between the input and result registers.
// a stalled receiver holds the result register; the input register still takes
//   one byte, then in_ready drops until the result is taken.
// reset: all records cleared, type codes back to 0..4, both channels empty.
`default_nettype none

module log_record_checker
    import lrc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        buffer_end,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [32:0]      record_size,
    output logic [31:0]      crc_value,
    output logic [31:0]      previous_crc,
    output logic [63:0]      log_id,
    output logic [63:0]      txn_number,
    output logic [7:0]       record_kind,
    output logic [63:0]      commit_number,
    output logic [31:0]      table_number,
    output logic [63:0]      first_row,
    output logic [63:0]      rows_affected,
    output logic [28:0]      row_id_count
);

    logic [7:0]  commit_code_reg, insert_code_reg, add_col_code_reg;
    logic [7:0]  delete_code_reg, update_code_reg;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_end_reg;
    logic        fire;

    logic [32:0] pos_reg;
    logic [31:0] blen_reg;
    logic [31:0] crc_reg;
    logic [31:0] scrc_reg;
    logic [31:0] prev_reg;
    logic [63:0] log_reg, txn_reg, commit_reg, first_reg, rows_reg;
    logic [7:0]  kind_reg;
    logic [31:0] table_reg, plen_reg;
    logic [2:0]  class_reg, class_next;

    logic        has_len, in_body, is_final, hdr_zone, done;
    logic [32:0] off, len33;
    logic [5:0]  o6, l_log, l_txn, l_com, l_first, l_rows, l_plen;
    logic [1:0]  crc_lane;
    logic [31:0] scrc_final, computed;

    frm_ctrl_t   fctrl;
    logic [2:0]  frame_status;
    logic [31:0] rid_bytes;

    logic        out_valid_reg;
    logic [2:0]  st;
    logic        hdr_on, commit_on, data_on, rid_on;
    logic [28:0] rid_val;
    logic [31:0] crc_out;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            commit_code_reg  <= 8'd0;
            insert_code_reg  <= 8'd1;
            add_col_code_reg <= 8'd2;
            delete_code_reg  <= 8'd3;
            update_code_reg  <= 8'd4;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_COMMIT:  commit_code_reg  <= cfg_data;
                REG_INSERT:  insert_code_reg  <= cfg_data;
                REG_ADD_COL: add_col_code_reg <= cfg_data;
                REG_DELETE:  delete_code_reg  <= cfg_data;
                REG_UPDATE:  update_code_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // input register
    assign fire     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= data_byte;
            s1_end_reg  <= buffer_end;
        end
    end

    // position decode
    assign len33    = {1'b0, blen_reg};
    assign has_len  = |pos_reg[32:2];
    assign off      = pos_reg - 33'd4;
    assign in_body  = has_len && (off < len33);
    assign is_final = has_len && (pos_reg == len33 + 33'd7);
    assign done     = is_final || s1_end_reg;
    assign hdr_zone = (off[32:6] == 27'd0);
    assign o6       = off[5:0];
    assign l_log    = o6 - 6'd4;
    assign l_txn    = o6 - 6'd12;
    assign l_com    = o6 - 6'd21;
    assign l_first  = o6 - 6'd25;
    assign l_rows   = o6 - 6'd33;
    assign l_plen   = o6 - 6'd41;
    assign crc_lane = off[1:0] - blen_reg[1:0];

    // type byte classification
    always_comb
    begin
        priority if (s1_byte_reg == commit_code_reg)
            class_next = CL_COMMIT;
        else if (s1_byte_reg == insert_code_reg || s1_byte_reg == add_col_code_reg)
            class_next = CL_BATCH;
        else if (s1_byte_reg == delete_code_reg)
            class_next = CL_DELETE;
        else if (s1_byte_reg == update_code_reg)
            class_next = CL_UPDATE;
        else
            class_next = CL_UNKNOWN;
    end

    // record control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 33'd0;
            crc_reg   <= 32'hFFFF_FFFF;
            class_reg <= CL_UNKNOWN;
        end
        else if (fire)
        begin
            if (done)
            begin
                pos_reg   <= 33'd0;
                crc_reg   <= 32'hFFFF_FFFF;
                class_reg <= CL_UNKNOWN;
            end
            else
            begin
                pos_reg <= pos_reg + 33'd1;
                if (in_body)
                    crc_reg <= crc_byte(crc_reg, s1_byte_reg);
                if (in_body && hdr_zone && o6 == 6'd20)
                    class_reg <= class_next;
            end
        end
    end

    // field capture, every lane is rewritten before it is used
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (!has_len)
                blen_reg[8*pos_reg[1:0] +: 8] <= s1_byte_reg;
            else if (!in_body)
                scrc_reg[8*crc_lane +: 8] <= s1_byte_reg;
            if (in_body && hdr_zone)
            begin
                if (o6 < 6'd4)
                    prev_reg[8*o6[1:0] +: 8] <= s1_byte_reg;
                if (o6 >= 6'd4 && o6 < 6'd12)
                    log_reg[8*l_log[2:0] +: 8] <= s1_byte_reg;
                if (o6 >= 6'd12 && o6 < 6'd20)
                    txn_reg[8*l_txn[2:0] +: 8] <= s1_byte_reg;
                if (o6 == 6'd20)
                    kind_reg <= s1_byte_reg;
                if (o6 >= 6'd21 && o6 < 6'd29)
                    commit_reg[8*l_com[2:0] +: 8] <= s1_byte_reg;
                if (o6 >= 6'd21 && o6 < 6'd25)
                    table_reg[8*l_com[1:0] +: 8] <= s1_byte_reg;
                if (o6 >= 6'd25 && o6 < 6'd33)
                    first_reg[8*l_first[2:0] +: 8] <= s1_byte_reg;
                if (o6 >= 6'd33 && o6 < 6'd41)
                    rows_reg[8*l_rows[2:0] +: 8] <= s1_byte_reg;
                if (o6 >= 6'd41 && o6 < 6'd45)
                    plen_reg[8*l_plen[1:0] +: 8] <= s1_byte_reg;
            end
        end
    end

    // payload framing
    always_comb
    begin
        fctrl.clear = fire && done;
        fctrl.start = fire && in_body && hdr_zone && (o6 == 6'd44);
        fctrl.take  = fire && in_body && (!hdr_zone || o6 >= 6'd45);
        unique case (class_reg)
            CL_BATCH:  fctrl.start_phase = PH_COUNT;
            CL_UPDATE: fctrl.start_phase = PH_IDS_LEN;
            default:   fctrl.start_phase = PH_IDLE;
        endcase
    end

    lrc_framer u_framer (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (fctrl),
        .data_byte    (s1_byte_reg),
        .frame_status (frame_status),
        .row_id_bytes (rid_bytes)
    );

    // record verdict
    assign scrc_final = {s1_byte_reg, scrc_reg[23:0]};
    assign computed   = ~crc_reg;

    always_comb
    begin
        st        = ST_OK;
        hdr_on    = 1'b0;
        commit_on = 1'b0;
        data_on   = 1'b0;
        rid_on    = 1'b0;
        rid_val   = 29'd0;
        crc_out   = computed;
        priority if (scrc_final != computed)
        begin
            st      = ST_CRC;
            crc_out = scrc_final;
        end
        else if (len33 < COMMIT_MIN)
            st = ST_SHORT;
        else if (class_reg == CL_COMMIT)
        begin
            hdr_on    = 1'b1;
            commit_on = 1'b1;
        end
        else if (len33 < DATA_HDR)
        begin
            hdr_on = 1'b1;
            st     = ST_SHORT;
        end
        else
        begin
            hdr_on  = 1'b1;
            data_on = 1'b1;
            priority if ({1'b0, plen_reg} + DATA_HDR != len33)
                st = ST_PAYLOAD;
            else if (class_reg == CL_UNKNOWN)
                st = ST_UNKNOWN;
            else if (class_reg == CL_BATCH)
                st = frame_status;
            else if (class_reg == CL_DELETE)
            begin
                if (plen_reg[2:0] != 3'd0)
                    st = ST_ROW_ID;
                else
                begin
                    rid_on  = 1'b1;
                    rid_val = plen_reg[31:3];
                end
            end
            else
            begin
                st = frame_status;
                if (frame_status != ST_ROW_ID)
                begin
                    rid_on  = 1'b1;
                    rid_val = rid_bytes[31:3];
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire && done)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && done)
        begin
            if (is_final)
            begin
                status        <= st;
                record_size   <= len33 + 33'd8;
                crc_value     <= crc_out;
                previous_crc  <= hdr_on ? prev_reg : 32'd0;
                log_id        <= hdr_on ? log_reg : 64'd0;
                txn_number    <= hdr_on ? txn_reg : 64'd0;
                record_kind   <= hdr_on ? kind_reg : 8'd0;
                commit_number <= commit_on ? commit_reg : 64'd0;
                table_number  <= data_on ? table_reg : 32'd0;
                first_row     <= data_on ? first_reg : 64'd0;
                rows_affected <= data_on ? rows_reg : 64'd0;
                row_id_count  <= rid_on ? rid_val : 29'd0;
            end
            else
            begin
                status        <= ST_TRUNC;
                record_size   <= 33'd0;
                crc_value     <= 32'd0;
                previous_crc  <= 32'd0;
                log_id        <= 64'd0;
                txn_number    <= 64'd0;
                record_kind   <= 8'd0;
                commit_number <= 64'd0;
                table_number  <= 32'd0;
                first_row     <= 64'd0;
                rows_affected <= 64'd0;
                row_id_count  <= 29'd0;
            end
        end
    end

    assign out_valid = out_valid_reg;

    // checks
    a_trunc_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_TRUNC |-> record_size == 33'd0)
        else $error("truncated result with nonzero size");

    a_ok_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |-> record_size >= RECORD_MIN)
        else $error("ok result on a record below minimum size");

    a_crc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_CRC |-> log_id == 64'd0 && commit_number == 64'd0)
        else $error("header fields given on crc mismatch");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fire && done |=> pos_reg == 33'd0)
        else $error("record state not cleared after result");

endmodule

`default_nettype wire

// File: hdl/lrc_framer.sv
`default_nettype none

module lrc_framer
    import lrc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire frm_ctrl_t   ctrl,
    input  wire logic [7:0]  data_byte,
    output logic [2:0]       frame_status,
    output logic [31:0]      row_id_bytes
);

    logic [2:0]  phase_reg, phase_next;
    logic [1:0]  fi_reg, fi_next;
    logic [23:0] acc_reg;
    logic [31:0] cl_reg, cl_next;
    logic [31:0] cbl_reg, cbl_next;
    logic [31:0] rid_reg, rid_next;
    logic [31:0] word;
    logic        word_done;
    logic        four_byte;

    assign word      = {data_byte, acc_reg};
    assign four_byte = (phase_reg == PH_IDS_LEN) || (phase_reg == PH_COUNT)
                       || (phase_reg == PH_LEN);
    assign word_done = ctrl.take && four_byte && (fi_reg == 2'd3);

    // framing walk over the payload
    always_comb
    begin
        phase_next = phase_reg;
        fi_next    = fi_reg;
        cl_next    = cl_reg;
        cbl_next   = cbl_reg;
        rid_next   = rid_reg;
        if (ctrl.clear)
        begin
            phase_next = PH_IDLE;
            fi_next    = 2'd0;
        end
        else if (ctrl.start)
        begin
            phase_next = ctrl.start_phase;
            fi_next    = 2'd0;
        end
        else if (ctrl.take)
        begin
            if (four_byte)
                fi_next = fi_reg + 2'd1;
            unique case (phase_reg)
                PH_IDS_LEN:
                begin
                    if (word_done)
                    begin
                        rid_next = word;
                        if (word[2:0] != 3'd0)
                            phase_next = PH_FAIL;
                        else if (word == 32'd0)
                            phase_next = PH_COUNT;
                        else
                        begin
                            cbl_next   = word;
                            phase_next = PH_IDS;
                        end
                    end
                end
                PH_IDS:
                begin
                    cbl_next = cbl_reg - 32'd1;
                    if (cbl_reg == 32'd1)
                        phase_next = PH_COUNT;
                end
                PH_COUNT:
                begin
                    if (word_done)
                    begin
                        cl_next    = word;
                        phase_next = (word != 32'd0) ? PH_LEN : PH_DONE;
                    end
                end
                PH_LEN:
                begin
                    if (word_done)
                    begin
                        if (word == 32'd0)
                        begin
                            cl_next    = cl_reg - 32'd1;
                            phase_next = (cl_reg != 32'd1) ? PH_LEN : PH_DONE;
                        end
                        else
                        begin
                            cbl_next   = word;
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    cbl_next = cbl_reg - 32'd1;
                    if (cbl_reg == 32'd1)
                    begin
                        cl_next    = cl_reg - 32'd1;
                        phase_next = (cl_reg != 32'd1) ? PH_LEN : PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            fi_reg    <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            fi_reg    <= fi_next;
        end
    end

    // counters and field bytes, the top byte of a word comes straight from the input
    always_ff @(posedge clk)
    begin
        cl_reg  <= cl_next;
        cbl_reg <= cbl_next;
        rid_reg <= rid_next;
        if (ctrl.take && four_byte && !ctrl.clear && !ctrl.start && (fi_reg != 2'd3))
            acc_reg[8*fi_reg +: 8] <= data_byte;
    end

    // status of the framing at record end
    always_comb
    begin
        unique case (phase_reg)
            PH_IDS_LEN, PH_IDS, PH_FAIL: frame_status = ST_ROW_ID;
            PH_COUNT:                    frame_status = (fi_reg != 2'd0) ? ST_FRAMING : ST_OK;
            PH_LEN, PH_DATA:             frame_status = ST_FRAMING;
            default:                     frame_status = ST_OK;
        endcase
    end

    assign row_id_bytes = rid_reg;

endmodule

`default_nettype wire
